/* design/eci_pkg.sv */
package eci_pkg;

	// Datapath widths.
	localparam int VW    = 52;  // vectoring x/y, Q16 metres
	localparam int AW    = 34;  // angles, units of pi/2^31
	localparam int RW    = 34;  // sine rotation x/y, Q30
	localparam int RHO_W = 49;  // equatorial distance, Q16 metres
	localparam int AC_W  = 40;  // a*C, Q16 metres

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;

	localparam logic [31:0]          INV_GAIN_Q32 = 32'd2608131496;
	localparam logic signed [RW-1:0] INV_GAIN_Q30 = 34'sd652032874;
	localparam logic [31:0]          RATE_LO      = 32'd2730362134;
	localparam logic [31:0]          RATE_HI      = 32'd45;
	localparam logic signed [AW-1:0] PI_ANG       = 34'sd2147483648;
	localparam logic signed [AW-1:0] HALF_ANG     = 34'sd1073741824;
	localparam logic [31:0]          DIV_SEED     = 32'h20000000;

	localparam int CFG_AW = 2;
	localparam logic [CFG_AW-1:0] REG_GMST = 2'd0;
	localparam logic [CFG_AW-1:0] REG_SEMI = 2'd1;
	localparam logic [CFG_AW-1:0] REG_ECC  = 2'd2;

	// Per-word side data that travels down the whole pipeline.
	typedef struct packed {
		logic                axis;
		logic                zpos;
		logic                zneg;
		logic [31:0]         lon;
		logic [RHO_W-1:0]    rho;
		logic signed [47:0]  z16;
		logic [30:0]         us;
		logic                sneg;
		logic [AC_W-1:0]     ac16;
	} item_t;

	function automatic logic [31:0] atan_entry(input int idx);
		logic [31:0] r;
		case (idx)
			0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
			3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
			9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
			12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
			15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
			18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
			21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
			24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
			27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
			30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

/* design/eci_to_geodetic_converter_core.sv */
// Throughput: one word per cycle; every CORDIC stage, square-root bit and divider bit
// is its own cell, and the whole pipeline advances whenever the output register is free.
// Reset: arst_n clears all valid bits at once and loads the register defaults
// (sidereal angle 0, a = 6378137 m, e^2 = 28752143 / 2^32).
module eci_to_geodetic_converter_core import eci_pkg::*; #(
	parameter int LAT_PASSES    = 3,
	parameter int CORDIC_STAGES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [31:0]       cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [143:0]      s_tdata,   // pos_x, pos_y, pos_z, minutes_since_epoch
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [95:0]       m_tdata,   // longitude, latitude, altitude
	output logic              m_tuser    // on_axis
);
	localparam int N = CORDIC_STAGES;
	localparam int P = LAT_PASSES;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Configuration registers.
	logic [31:0] gmst_q;
	logic [22:0] semi_q;
	logic [29:0] ecc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gmst_q <= 32'd0;
			semi_q <= 23'd6378137;
			ecc_q  <= 30'd28752143;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_GMST: gmst_q <= cfg_wdata;
				REG_SEMI: semi_q <= cfg_wdata[22:0];
				REG_ECC:  ecc_q  <= cfg_wdata[29:0];
				default: ;
			endcase
		end
	end

	// Front stage: unpack, fold into the right half plane, start the sidereal product.
	logic signed [31:0] in_x, in_y, in_z;
	logic signed [47:0] in_mu;
	logic signed [VW-1:0] xw, yw;
	assign in_x  = s_tdata[31:0];
	assign in_y  = s_tdata[63:32];
	assign in_z  = s_tdata[95:64];
	assign in_mu = s_tdata[143:96];
	assign xw    = {{(VW-48){in_x[31]}}, in_x, 16'h0000};
	assign yw    = {{(VW-48){in_y[31]}}, in_y, 16'h0000};

	logic v_s1, neg_s1, axis_s1, zpos_s1, zneg_s1;
	logic signed [VW-1:0] xs_s1, ys_s1;
	logic [55:0] p1_s1;
	logic signed [56:0] p2_s1;
	logic [31:0] p3_s1;
	logic signed [47:0] z16_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= in_x[31];
			xs_s1   <= in_x[31] ? -xw : xw;
			ys_s1   <= in_x[31] ? -yw : yw;
			axis_s1 <= (in_x == 32'sd0) && (in_y == 32'sd0);
			zpos_s1 <= !in_z[31] && (in_z != 32'sd0);
			zneg_s1 <= in_z[31];
			z16_s1  <= {in_z, 16'h0000};
			p1_s1   <= in_mu[23:0] * RATE_LO;
			p2_s1   <= $signed(in_mu[47:24]) * $signed({1'b0, RATE_LO});
			p3_s1   <= in_mu[31:0] * RATE_HI;
		end
	end

	// Second stage: sidereal angle, upper half of minutes * rate, modulo 2^64.
	logic [63:0] prod64;
	logic [31:0] theta;
	assign prod64 = ({{7{p2_s1[56]}}, p2_s1} << 24) + {8'h00, p1_s1};
	assign theta  = gmst_q + prod64[63:32] + p3_s1;

	item_t it2_d, it_s2;
	always_comb begin
		it2_d      = '0;
		it2_d.axis = axis_s1;
		it2_d.zpos = zpos_s1;
		it2_d.zneg = zneg_s1;
		it2_d.lon  = theta;
		it2_d.z16  = z16_s1;
	end

	logic v_s2;
	logic signed [VW-1:0] xs_s2, ys_s2;
	logic signed [AW-1:0] a0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= it2_d;
			xs_s2 <= xs_s1;
			ys_s2 <= ys_s1;
			a0_s2 <= neg_s1 ? PI_ANG : '0;
		end
	end

	// Longitude chain.
	logic av [0:N];
	logic signed [VW-1:0] ax [0:N];
	logic signed [VW-1:0] ay [0:N];
	logic signed [AW-1:0] aa [0:N];
	item_t ai [0:N];
	assign av[0] = v_s2;
	assign ax[0] = xs_s2;
	assign ay[0] = ys_s2;
	assign aa[0] = a0_s2;
	assign ai[0] = it_s2;

	for (genvar g = 0; g < N; g++) begin : g_lon
		eci_vec_cell #(.STAGE(g), .W(VW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vi(av[g]), .xi(ax[g]), .yi(ay[g]), .ai(aa[g]), .ii(ai[g]),
			.vo(av[g+1]), .xo(ax[g+1]), .yo(ay[g+1]), .ao(aa[g+1]), .io(ai[g+1])
		);
	end

	// Gain correction of the equatorial distance, split over two stages.
	item_t it3_d, it_s3, it4_d, it_s4;
	logic v_s3, v_s4;
	logic [50:0] gh_s3;
	logic [63:0] gl_s3;
	logic [50:0] rho_sum;

	always_comb begin
		it3_d     = ai[N];
		it3_d.lon = ai[N].axis ? 32'(-ai[N].lon) : aa[N][31:0] - ai[N].lon;
	end

	assign rho_sum = gh_s3 + 51'(gl_s3[63:32]);

	always_comb begin
		it4_d     = it_s3;
		it4_d.rho = rho_sum[RHO_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= av[N];
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s3 <= it3_d;
			gh_s3 <= ax[N][50:32] * INV_GAIN_Q32;
			gl_s3 <= ax[N][31:0] * INV_GAIN_Q32;
			it_s4 <= it4_d;
		end
	end

	// Geocentric latitude chain.
	logic bv [0:N];
	logic signed [VW-1:0] bx [0:N];
	logic signed [VW-1:0] by [0:N];
	logic signed [AW-1:0] ba [0:N];
	item_t bi [0:N];
	assign bv[0] = v_s4;
	assign bx[0] = {{(VW-RHO_W){1'b0}}, it_s4.rho};
	assign by[0] = {{(VW-48){it_s4.z16[47]}}, it_s4.z16};
	assign ba[0] = '0;
	assign bi[0] = it_s4;

	for (genvar g = 0; g < N; g++) begin : g_geo
		eci_vec_cell #(.STAGE(g), .W(VW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vi(bv[g]), .xi(bx[g]), .yi(by[g]), .ai(ba[g]), .ii(bi[g]),
			.vo(bv[g+1]), .xo(bx[g+1]), .yo(by[g+1]), .ao(ba[g+1]), .io(bi[g+1])
		);
	end

	logic lp_v [0:P];
	logic signed [AW-1:0] lp_a [0:P];
	logic signed [VW-1:0] lp_x [0:P];
	item_t lp_i [0:P];
	assign lp_v[0] = bv[N];
	assign lp_a[0] = ba[N];
	assign lp_x[0] = bx[N];
	assign lp_i[0] = bi[N];

	for (genvar p = 0; p < P; p++) begin : g_pass
		// Sine of the previous latitude.
		logic rv [0:N];
		logic signed [RW-1:0] rx [0:N];
		logic signed [RW-1:0] ry [0:N];
		logic signed [AW-1:0] ra [0:N];
		item_t ri [0:N];
		assign rv[0] = lp_v[p];
		assign rx[0] = INV_GAIN_Q30;
		assign ry[0] = '0;
		assign ra[0] = lp_a[p];
		assign ri[0] = lp_i[p];

		for (genvar g = 0; g < N; g++) begin : g_sin
			eci_rot_cell #(.STAGE(g), .W(RW)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vi(rv[g]), .xi(rx[g]), .yi(ry[g]), .ai(ra[g]), .ii(ri[g]),
				.vo(rv[g+1]), .xo(rx[g+1]), .yo(ry[g+1]), .ao(ra[g+1]), .io(ri[g+1])
			);
		end

		logic signed [RW-1:0] sc;
		logic [30:0] us_c;
		item_t it1_d, it_s1, it_s2, it_s3;
		logic v_s1, v_s2, v_s3;
		logic [61:0] sq;
		logic [30:0] s2_s2;
		logic [60:0] eq;
		logic [30:0] q_c;
		logic [62:0] qv_s3;

		always_comb begin
			if (ry[N] > $signed(RW'(HALF_ANG))) begin
				sc = RW'(HALF_ANG);
			end else if (ry[N] < -$signed(RW'(HALF_ANG))) begin
				sc = -RW'(HALF_ANG);
			end else begin
				sc = ry[N];
			end
			us_c       = sc[RW-1] ? 31'(-sc) : 31'(sc);
			it1_d      = ri[N];
			it1_d.us   = us_c;
			it1_d.sneg = sc[RW-1];
		end

		assign sq  = it_s1.us * it_s1.us;
		assign eq  = ecc_q * s2_s2;
		assign q_c = 31'h40000000 - {2'b00, eq[60:32]};

		// Root of q * 2^30, then 2^60 over that root.
		logic sv [0:SQRT_STEPS];
		logic [62:0] srm [0:SQRT_STEPS];
		logic [62:0] srt [0:SQRT_STEPS];
		item_t si [0:SQRT_STEPS];
		assign sv[0]  = v_s3;
		assign srm[0] = qv_s3;
		assign srt[0] = '0;
		assign si[0]  = it_s3;

		for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
			eci_sqrt_cell #(.STAGE(k)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vi(sv[k]), .rem_i(srm[k]), .root_i(srt[k]), .ii(si[k]),
				.vo(sv[k+1]), .rem_o(srm[k+1]), .root_o(srt[k+1]), .io(si[k+1])
			);
		end

		logic dv [0:DIV_STEPS];
		logic [31:0] drm [0:DIV_STEPS];
		logic [30:0] dq [0:DIV_STEPS];
		logic [31:0] dd [0:DIV_STEPS];
		item_t di [0:DIV_STEPS];
		assign dv[0]  = sv[SQRT_STEPS];
		assign drm[0] = DIV_SEED;
		assign dq[0]  = '0;
		assign dd[0]  = srt[SQRT_STEPS][31:0];
		assign di[0]  = si[SQRT_STEPS];

		for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
			eci_div_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vi(dv[k]), .rem_i(drm[k]), .quo_i(dq[k]), .den_i(dd[k]), .ii(di[k]),
				.vo(dv[k+1]), .rem_o(drm[k+1]), .quo_o(dq[k+1]), .den_o(dd[k+1]),
				.io(di[k+1])
			);
		end

		// a*C, then the z offset a*C*e^2*|sin|, each product in its own stage.
		logic [53:0] acp;
		item_t it4_d, it_s4, it_s5, it_s6, it_s7, it_s8, it_s9;
		logic v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
		logic [37:0] mh_s5;
		logic [61:0] ml_s5;
		logic [38:0] t1_s6;
		logic [37:0] nh_s7;
		logic [62:0] nl_s7;
		logic [40:0] t_s8;
		logic signed [VW-1:0] z_ext, t_ext, zp_s9;

		assign acp = semi_q * dq[DIV_STEPS];
		always_comb begin
			it4_d      = di[DIV_STEPS];
			it4_d.ac16 = acp[53:14];
		end
		assign z_ext = {{(VW-48){it_s8.z16[47]}}, it_s8.z16};
		assign t_ext = {{(VW-41){1'b0}}, t_s8};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
				v_s3 <= 1'b0;
				v_s4 <= 1'b0;
				v_s5 <= 1'b0;
				v_s6 <= 1'b0;
				v_s7 <= 1'b0;
				v_s8 <= 1'b0;
				v_s9 <= 1'b0;
			end else if (en) begin
				v_s1 <= rv[N];
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= dv[DIV_STEPS];
				v_s5 <= v_s4;
				v_s6 <= v_s5;
				v_s7 <= v_s6;
				v_s8 <= v_s7;
				v_s9 <= v_s8;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				it_s1 <= it1_d;
				it_s2 <= it_s1;
				s2_s2 <= sq[60:30];
				it_s3 <= it_s2;
				qv_s3 <= {2'b00, q_c, 30'h0};
				it_s4 <= it4_d;
				it_s5 <= it_s4;
				mh_s5 <= it_s4.ac16[39:32] * ecc_q;
				ml_s5 <= it_s4.ac16[31:0] * ecc_q;
				it_s6 <= it_s5;
				t1_s6 <= 39'(mh_s5) + 39'(ml_s5[61:32]);
				it_s7 <= it_s6;
				nh_s7 <= t1_s6[38:32] * it_s6.us;
				nl_s7 <= t1_s6[31:0] * it_s6.us;
				it_s8 <= it_s7;
				t_s8  <= {1'b0, nh_s7, 2'b00} + 41'(nl_s7[62:30]);
				it_s9 <= it_s8;
				zp_s9 <= it_s8.sneg ? z_ext - t_ext : z_ext + t_ext;
			end
		end

		// Refined latitude from (rho, z').
		logic cv [0:N];
		logic signed [VW-1:0] cx [0:N];
		logic signed [VW-1:0] cy [0:N];
		logic signed [AW-1:0] ca [0:N];
		item_t ci [0:N];
		assign cv[0] = v_s9;
		assign cx[0] = {{(VW-RHO_W){1'b0}}, it_s9.rho};
		assign cy[0] = zp_s9;
		assign ca[0] = '0;
		assign ci[0] = it_s9;

		for (genvar g = 0; g < N; g++) begin : g_lat
			eci_vec_cell #(.STAGE(g), .W(VW)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.vi(cv[g]), .xi(cx[g]), .yi(cy[g]), .ai(ca[g]), .ii(ci[g]),
				.vo(cv[g+1]), .xo(cx[g+1]), .yo(cy[g+1]), .ao(ca[g+1]), .io(ci[g+1])
			);
		end

		assign lp_v[p+1] = cv[N];
		assign lp_a[p+1] = ca[N];
		assign lp_x[p+1] = cx[N];
		assign lp_i[p+1] = ci[N];
	end

	// Final magnitude, altitude and output register.
	logic v_f1, v_f2;
	item_t it_f1, it_f2;
	logic signed [AW-1:0] lat_f1, lat_f2;
	logic [50:0] fh_f1, mag_f2;
	logic [63:0] fl_f1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1     <= 1'b0;
			v_f2     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_f1     <= lp_v[P];
			v_f2     <= v_f1;
			m_tvalid <= v_f2;
		end
	end

	logic signed [51:0] alt16;
	logic signed [35:0] alt_sh;
	logic [31:0] alt_c, lat_c, lat_axis;

	assign alt16  = $signed({1'b0, mag_f2}) - $signed({12'h000, it_f2.ac16});
	assign alt_sh = alt16[51:16];

	always_comb begin
		if (alt_sh > 36'sd2147483647) begin
			alt_c = 32'h7FFFFFFF;
		end else if (alt_sh < -36'sd2147483648) begin
			alt_c = 32'h80000000;
		end else begin
			alt_c = alt_sh[31:0];
		end
		if (lat_f2 > HALF_ANG) begin
			lat_c = HALF_ANG[31:0];
		end else if (lat_f2 < -HALF_ANG) begin
			lat_c = 32'(-HALF_ANG);
		end else begin
			lat_c = lat_f2[31:0];
		end
		if (it_f2.zpos) begin
			lat_axis = HALF_ANG[31:0];
		end else if (it_f2.zneg) begin
			lat_axis = 32'(-HALF_ANG);
		end else begin
			lat_axis = 32'h0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_f1  <= lp_i[P];
			lat_f1 <= lp_a[P];
			fh_f1  <= lp_x[P][50:32] * INV_GAIN_Q32;
			fl_f1  <= lp_x[P][31:0] * INV_GAIN_Q32;
			it_f2  <= it_f1;
			lat_f2 <= lat_f1;
			mag_f2 <= fh_f1 + 51'(fl_f1[63:32]);
			m_tdata[31:0]  <= it_f2.lon;
			m_tdata[63:32] <= it_f2.axis ? lat_axis : lat_c;
			m_tdata[95:64] <= it_f2.axis ? 32'h0 : alt_c;
			m_tuser        <= it_f2.axis;
		end
	end

`ifndef SYNTHESIS
	a_axis_alt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[95:64] == 32'h0)
		else $error("on-axis word with nonzero altitude");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[63:32]) <= 32'sd1073741824) &&
			($signed(m_tdata[63:32]) >= -32'sd1073741824))
		else $error("latitude outside half a turn");
`endif
endmodule

/* design/eci_vec_cell.sv */
module eci_vec_cell import eci_pkg::*; #(
	parameter int STAGE = 0,
	parameter int W = 52
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vi,
	input  logic signed [W-1:0] xi,
	input  logic signed [W-1:0] yi,
	input  logic signed [AW-1:0] ai,
	input  item_t               ii,
	output logic                vo,
	output logic signed [W-1:0] xo,
	output logic signed [W-1:0] yo,
	output logic signed [AW-1:0] ao,
	output item_t               io
);
	localparam logic signed [AW-1:0] ATAN = AW'(atan_entry(STAGE));

	logic signed [W-1:0] dx, dy;
	assign dx = yi >>> STAGE;
	assign dy = xi >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo <= 1'b0;
		end else if (en) begin
			vo <= vi;
		end
	end

	// Drive y toward zero; the angle collects the rotation applied.
	always_ff @(posedge clk) begin
		if (en) begin
			io <= ii;
			if (!yi[W-1]) begin
				xo <= xi + dx;
				yo <= yi - dy;
				ao <= ai + ATAN;
			end else begin
				xo <= xi - dx;
				yo <= yi + dy;
				ao <= ai - ATAN;
			end
		end
	end
endmodule

/* design/eci_rot_cell.sv */
module eci_rot_cell import eci_pkg::*; #(
	parameter int STAGE = 0,
	parameter int W = 34
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vi,
	input  logic signed [W-1:0] xi,
	input  logic signed [W-1:0] yi,
	input  logic signed [AW-1:0] ai,
	input  item_t               ii,
	output logic                vo,
	output logic signed [W-1:0] xo,
	output logic signed [W-1:0] yo,
	output logic signed [AW-1:0] ao,
	output item_t               io
);
	localparam logic signed [AW-1:0] ATAN = AW'(atan_entry(STAGE));

	logic signed [W-1:0] dx, dy;
	assign dx = yi >>> STAGE;
	assign dy = xi >>> STAGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo <= 1'b0;
		end else if (en) begin
			vo <= vi;
		end
	end

	// Rotate the vector to drive the residual angle toward zero.
	always_ff @(posedge clk) begin
		if (en) begin
			io <= ii;
			if (!ai[AW-1]) begin
				xo <= xi - dx;
				yo <= yi + dy;
				ao <= ai - ATAN;
			end else begin
				xo <= xi + dx;
				yo <= yi - dy;
				ao <= ai + ATAN;
			end
		end
	end
endmodule

/* design/eci_sqrt_cell.sv */
module eci_sqrt_cell import eci_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vi,
	input  logic [62:0] rem_i,
	input  logic [62:0] root_i,
	input  item_t       ii,
	output logic        vo,
	output logic [62:0] rem_o,
	output logic [62:0] root_o,
	output item_t       io
);
	localparam logic [62:0] BIT = 63'(1) << (62 - 2 * STAGE);

	logic [62:0] trial;
	assign trial = root_i + BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo <= 1'b0;
		end else if (en) begin
			vo <= vi;
		end
	end

	// One result bit per cell, digit by digit.
	always_ff @(posedge clk) begin
		if (en) begin
			io <= ii;
			if (rem_i >= trial) begin
				rem_o  <= rem_i - trial;
				root_o <= (root_i >> 1) + BIT;
			end else begin
				rem_o  <= rem_i;
				root_o <= root_i >> 1;
			end
		end
	end
endmodule

/* design/eci_div_cell.sv */
module eci_div_cell import eci_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vi,
	input  logic [31:0] rem_i,
	input  logic [30:0] quo_i,
	input  logic [31:0] den_i,
	input  item_t       ii,
	output logic        vo,
	output logic [31:0] rem_o,
	output logic [30:0] quo_o,
	output logic [31:0] den_o,
	output item_t       io
);
	logic [32:0] shifted;
	assign shifted = {rem_i, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo <= 1'b0;
		end else if (en) begin
			vo <= vi;
		end
	end

	// Restoring division, one quotient bit per cell.
	always_ff @(posedge clk) begin
		if (en) begin
			io    <= ii;
			den_o <= den_i;
			if (shifted >= {1'b0, den_i}) begin
				rem_o <= 32'(shifted - {1'b0, den_i});
				quo_o <= {quo_i[29:0], 1'b1};
			end else begin
				rem_o <= shifted[31:0];
				quo_o <= {quo_i[29:0], 1'b0};
			end
		end
	end
endmodule

/* tb/sv/eci_geodetic_checker.sv */
`timescale 1ns / 1ps

module eci_geodetic_checker import eci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [31:0]       cfg_wdata,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [143:0]      s_tdata,   // pos_x, pos_y, pos_z, minutes_since_epoch
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [95:0]       m_tdata,   // longitude, latitude, altitude
	input  logic              m_tuser,   // on_axis
	output int                errors,
	output int                pending,
	output int                fixes_seen
);

	typedef struct {
		logic [31:0] lon;
		logic [31:0] lat;
		logic [31:0] alt;
		logic        axis;
	} fix_t;

	localparam int PASSES = 3;
	localparam int STAGES = 32;

	logic [31:0] gmst_q;
	logic [22:0] semi_q;
	logic [29:0] ecc_q;
	fix_t        fix_q[$];

	function automatic longint arctan_step(input int i);
		return longint'(atan_entry(i));
	endfunction

	// floor(a*b / 2^sh) without 64-bit overflow.
	function automatic longint unsigned mul_shift(input longint unsigned a,
			input longint unsigned b, input int sh);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return 64'(p >> sh);
	endfunction

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned r, bit_w;
		r = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= r + bit_w) begin
				v -= r + bit_w;
				r = (r >> 1) + bit_w;
			end else begin
				r >>= 1;
			end
			bit_w >>= 2;
		end
		return r;
	endfunction

	// CORDIC vectoring: returns the angle, mag gets the gain-corrected length.
	function automatic longint vector_angle(input longint x, input longint y,
			output longint mag);
		longint ang, dx, dy;
		ang = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; ang += arctan_step(i);
			end else begin
				x -= dx; y += dy; ang -= arctan_step(i);
			end
		end
		mag = longint'(mul_shift(x, 64'(INV_GAIN_Q32), 32));
		return ang;
	endfunction

	function automatic longint sine_of(input longint ang);
		longint x, y, dx, dy;
		x = 652032874;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (ang >= 0) begin
				x -= dx; y += dy; ang -= arctan_step(i);
			end else begin
				x += dx; y -= dy; ang += arctan_step(i);
			end
		end
		if (y > 1073741824) y = 1073741824;
		if (y < -1073741824) y = -1073741824;
		return y;
	endfunction

	function automatic fix_t geodetic_fix(input logic [143:0] w);
		fix_t f;
		longint x, y, z, xs, ys, ang, rho, mag, latp, z16, zp, s, alt, lat;
		longint unsigned mu, us, s2, q, c, t, ac16, a, e2;
		logic [63:0] prod;
		logic [31:0] theta;
		x = longint'($signed(w[31:0]));
		y = longint'($signed(w[63:32]));
		z = longint'($signed(w[95:64]));
		mu = 64'($signed(w[143:96]));
		prod = mu * 64'd196003890454;
		theta = gmst_q + prod[63:32];
		f.axis = (x == 0 && y == 0);
		if (f.axis) begin
			f.lon = 32'd0 - theta;
			f.lat = z > 0 ? 32'h40000000 : (z < 0 ? 32'hC0000000 : 32'd0);
			f.alt = 32'd0;
			return f;
		end
		a = 64'(semi_q);
		e2 = 64'(ecc_q);
		ac16 = 0;
		xs = x * 65536;
		ys = y * 65536;
		ang = 0;
		if (xs < 0) begin
			xs = -xs; ys = -ys; ang = 64'sd2147483648;
		end
		ang += vector_angle(xs, ys, rho);
		f.lon = ang[31:0] - theta;
		z16 = z * 65536;
		latp = vector_angle(rho, z16, mag);
		for (int p = 0; p < PASSES; p++) begin
			s = sine_of(latp);
			us = s < 0 ? -s : s;
			s2 = (us * us) >> 30;
			q = (64'd1 << 30) - ((e2 * s2) >> 32);
			c = (64'd1 << 60) / root64(q << 30);
			ac16 = (a * c) >> 14;
			t = mul_shift(mul_shift(ac16, e2, 32), us, 30);
			zp = z16 + (s < 0 ? -longint'(t) : longint'(t));
			latp = vector_angle(rho, zp, mag);
		end
		alt = (mag - longint'(ac16)) >>> 16;
		if (alt > 64'sd2147483647) alt = 64'sd2147483647;
		if (alt < -64'sd2147483648) alt = -64'sd2147483648;
		lat = latp;
		if (lat > 1073741824) lat = 1073741824;
		if (lat < -1073741824) lat = -1073741824;
		f.alt = alt[31:0];
		f.lat = lat[31:0];
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fix_t e;
		if (!arst_n) begin
			gmst_q     <= 32'd0;
			semi_q     <= 23'd6378137;
			ecc_q      <= 30'd28752143;
			errors     <= 0;
			fixes_seen <= 0;
			pending    <= 0;
			fix_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_GMST: gmst_q <= cfg_wdata;
					REG_SEMI: semi_q <= cfg_wdata[22:0];
					REG_ECC:  ecc_q  <= cfg_wdata[29:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				fix_q.push_back(geodetic_fix(s_tdata));
			if (m_tvalid && m_tready) begin
				fixes_seen <= fixes_seen + 1;
				if (fix_q.size() == 0) begin
					$display("%0t: unexpected word %h axis %b", $time, m_tdata, m_tuser);
					errors <= errors + 1;
				end else begin
					e = fix_q.pop_front();
					if (e.lon !== m_tdata[31:0] || e.lat !== m_tdata[63:32] ||
							e.alt !== m_tdata[95:64] || e.axis !== m_tuser) begin
						$display("%0t: mismatch lon/lat/alt/axis exp %h %h %h %b act %h %h %h %b",
							$time, e.lon, e.lat, e.alt, e.axis,
							m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser);
						errors <= errors + 1;
					end
				end
			end
			pending <= fix_q.size();
		end
	end

endmodule

/* tb/sv/eci_to_geodetic_converter_core_tb.sv */
`timescale 1ns / 1ps

module eci_to_geodetic_converter_core_tb import eci_pkg::*;;

	localparam int LATENCY    = 479;
	localparam int STALL_LEN  = 700;
	localparam int IDLE_LIMIT = 20000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [31:0]       cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [143:0]      s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [95:0]       m_tdata;
	logic              m_tuser;

	int   errors, pending, fixes_seen;
	int   words_sent;
	int   idle_cycles;
	logic in_fire;
	logic hold_req;
	logic quiet;

	eci_to_geodetic_converter_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	eci_geodetic_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending), .fixes_seen(fixes_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		in_fire <= s_tvalid && s_tready;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: short random stalls, one long hold-off on request, none at the end.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (STALL_LEN - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 2)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [47:0] mins);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {mins, z, y, x};
		do @(negedge clk); while (!in_fire);
		words_sent++;
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
	endtask

	// Mostly orbit-like positions, some raw bit patterns and points on or next to the polar axis.
	task automatic send_random(input int n);
		logic [31:0] x, y, z;
		logic [47:0] mins;
		int r, kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			mins = 48'({$urandom, $urandom});
			if ($urandom_range(0, 1)) mins = 48'($signed($urandom_range(0, 200000000)) - 100000000);
			if (kind < 6) begin
				r = $urandom_range(6300000, 42000000);
				x = $urandom_range(0, 2 * r) - r;
				y = $urandom_range(0, 2 * r) - r;
				z = $urandom_range(0, 2 * r) - r;
			end else if (kind < 9) begin
				x = $urandom; y = $urandom; z = $urandom;
			end else begin
				x = 32'd0; y = 32'd0; z = $urandom;
				if ($urandom_range(0, 1)) x = $urandom_range(0, 2) - 1;
			end
			send_word(x, y, z, mins);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = REG_GMST;
		cfg_wdata = 32'd0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		hold_req  = 1'b0;
		quiet     = 1'b0;
		words_sent = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes and the polar axis, default registers.
		send_word(32'd0, 32'd0, 32'd1000, 48'd0);
		send_word(32'd0, 32'd0, 32'hFFFFFC18, 48'd65536);
		send_word(32'd0, 32'd0, 32'd0, 48'hFFFFFFFFFFFF);
		send_word(32'h80000000, 32'h80000000, 32'h80000000, 48'h800000000000);
		send_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 48'h7FFFFFFFFFFF);
		send_word(32'h80000000, 32'd0, 32'd0, 48'd0);
		send_word(32'd0, 32'h7FFFFFFF, 32'd0, 48'd1);
		send_word(32'd6378137, 32'd0, 32'd0, 48'd0);
		send_word(32'hFF9EAD17, 32'd0, 32'd0, 48'd94371840);
		send_word(32'd0, 32'd0, 32'h80000000, 48'd0);
		send_word(32'd1, 32'd0, 32'd6356752, 48'd0);
		send_word(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 48'hFFFF00000000);
		send_word(32'd4000000, 32'hFFC2F700, 32'd4500000, 48'd123456789);
		send_word(32'd7000000, 32'd0, 32'hFF953000, 48'hFFFFF0000000);
		drain();

		write_reg(REG_GMST, 32'hFFFFFFFF);
		write_reg(REG_SEMI, 32'd7000000);
		write_reg(REG_ECC, 32'h3FFFFFFF);
		send_word(32'd0, 32'd0, 32'd5, 48'd0);
		send_word(32'd6378137, 32'd100, 32'd6000000, 48'd1000);
		send_word(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 48'h800000000000);
		send_random(300);
		drain();

		write_reg(REG_GMST, $urandom);
		write_reg(REG_SEMI, 32'd6000000);
		write_reg(REG_ECC, 32'd0);
		send_random(300);
		drain();

		write_reg(REG_GMST, $urandom);
		write_reg(REG_SEMI, $urandom_range(6000000, 7000000));
		write_reg(REG_ECC, $urandom_range(0, 32'h3FFFFFFF));
		send_random(200);
		hold_req = 1'b1;
		send_random(400);
		drain();

		write_reg(REG_GMST, 32'd0);
		write_reg(REG_SEMI, 32'd6378137);
		write_reg(REG_ECC, 32'd28752143);
		send_random(150);
		quiet = 1'b1;
		send_random(150);
		drain();

		$display("Sent %0d position words over five register settings, %0d fixes checked.",
			words_sent, fixes_seen);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
